@@ hdl/skt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types, widths and codes of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Default sizes of the table
  localparam int unsigned CAPACITY_DEF     = 64;
  localparam int unsigned KEY_BITS_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  // Field widths on the stream ports
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned PAYLOAD_W = 16;
  localparam int unsigned RANK_W    = 6;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned COUNT_W   = 7;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Operation codes
  localparam logic [CMD_W-1:0] OP_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] OP_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] OP_READ   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the command and compare it against every entry
    logic execute;   // apply the update and load the result register
  } skt_ctrl_t;

endpackage

@@ hdl/skt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: accepts a command, runs the update step once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output skt_pkg::skt_ctrl_t ctrl
);
  import skt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   capture, execute;

  assign in_tready  = (state_r == S_IDLE);
  assign capture    = in_tvalid && in_tready;
  // hold the update until the previous result has been taken
  assign execute    = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  assign ctrl.capture = capture;
  assign ctrl.execute = execute;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (execute) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hdl/skt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_datapath
// Ordered chain of key/payload entries with a comparator per entry, the
// shift network for insert and delete, and the result register.
// ----------------------------------------------------------------------------
module skt_datapath #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS     = skt_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  skt_pkg::skt_ctrl_t             ctrl,
  input  logic [skt_pkg::CMD_W-1:0]      in_cmd,
  input  logic [skt_pkg::KEY_W-1:0]      in_key,
  input  logic [skt_pkg::PAYLOAD_W-1:0]  in_payload,
  input  logic [skt_pkg::RANK_W-1:0]     in_rank,
  output logic [skt_pkg::STATUS_W-1:0]   out_status,
  output logic [skt_pkg::KEY_W-1:0]      out_key,
  output logic [skt_pkg::PAYLOAD_W-1:0]  out_payload,
  output logic [skt_pkg::COUNT_W-1:0]    out_count
);
  import skt_pkg::*;

  // stored widths: the field is masked down to the parameter
  localparam int unsigned KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned PW = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KW-1:0]       key_r [CAPACITY];
  logic [PW-1:0]       pay_r [CAPACITY];
  logic [CAPACITY-1:0] lt_r;     // entry valid and below the key
  logic [CAPACITY-1:0] eq_r;     // entry valid and equal to the key
  logic [CAPACITY-1:0] sel_r;    // entry sits at the requested rank
  logic [CW-1:0]       count_r, count_nxt;

  logic [CMD_W-1:0]    op_r;
  logic [KW-1:0]       key_in_r;
  logic [PW-1:0]       pay_in_r;
  logic [RANK_W-1:0]   rank_r;

  logic [STATUS_W-1:0]  status_r;
  logic [KEY_W-1:0]     key_out_r;
  logic [PAYLOAD_W-1:0] pay_out_r;
  logic [COUNT_W-1:0]   count_out_r;

  logic [KW-1:0] key_m;
  logic          hit, empty, full, out_of_range;
  logic          ins_en, del_en;
  logic [STATUS_W-1:0] status_nxt;
  logic [CAPACITY-1:0] pick;
  logic [KW-1:0] key_pick;
  logic [PW-1:0] pay_pick;
  logic [31:0]   count_ext;

  assign key_m = in_key[KW-1:0];

  // parallel compare at accept time
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    logic valid_g;
    assign valid_g = (CW'(g) < count_r);
    always_ff @(posedge clk) begin
      if (ctrl.capture) begin
        lt_r[g]  <= valid_g && (key_r[g] < key_m);
        eq_r[g]  <= valid_g && (key_r[g] == key_m);
        sel_r[g] <= (32'(in_rank) == 32'(g));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op_r     <= in_cmd;
      key_in_r <= key_m;
      pay_in_r <= in_payload[PW-1:0];
      rank_r   <= in_rank;
    end
  end

  assign hit          = |eq_r;
  assign empty        = (count_r == '0);
  assign full         = (count_r == CW'(CAPACITY));
  assign out_of_range = (32'(rank_r) >= 32'(count_r));

  always_comb begin
    status_nxt = ST_OK;
    ins_en     = 1'b0;
    del_en     = 1'b0;
    count_nxt  = count_r;
    case (op_r)
      OP_INSERT: begin
        if (hit) begin
          status_nxt = ST_DUP;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ins_en    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_SEARCH: begin
        if (empty)     status_nxt = ST_EMPTY;
        else if (!hit) status_nxt = ST_NOTFOUND;
      end
      OP_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOTFOUND;
        end else begin
          del_en    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (empty)             status_nxt = ST_EMPTY;
        else if (out_of_range) status_nxt = ST_RANGE;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  // shift network: insert opens a slot at the first entry not below the key,
  // delete closes the slot of the matching entry
  for (genvar g = 0; g < CAPACITY; g++) begin : g_ent
    always_ff @(posedge clk) begin
      if (ctrl.execute && ins_en) begin
        if (g == 0) begin
          if (!lt_r[g]) begin
            key_r[g] <= key_in_r;
            pay_r[g] <= pay_in_r;
          end
        end else begin
          if (!lt_r[(g == 0) ? 0 : g - 1]) begin
            key_r[g] <= key_r[(g == 0) ? 0 : g - 1];
            pay_r[g] <= pay_r[(g == 0) ? 0 : g - 1];
          end else if (!lt_r[g]) begin
            key_r[g] <= key_in_r;
            pay_r[g] <= pay_in_r;
          end
        end
      end else if (ctrl.execute && del_en) begin
        if ((g < CAPACITY - 1) && !lt_r[g]) begin
          key_r[g] <= key_r[(g < CAPACITY - 1) ? g + 1 : g];
          pay_r[g] <= pay_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  // one-hot select of the found or ranked entry
  assign pick = (op_r == OP_SEARCH) ? eq_r : sel_r;

  always_comb begin
    key_pick = '0;
    pay_pick = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      key_pick = key_pick | ({KW{pick[i]}} & key_r[i]);
      pay_pick = pay_pick | ({PW{pick[i]}} & pay_r[i]);
    end
  end

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      status_r    <= status_nxt;
      count_out_r <= count_ext[COUNT_W-1:0];
      if ((status_nxt == ST_OK) && ((op_r == OP_SEARCH) || (op_r == OP_READ))) begin
        key_out_r <= KEY_W'(key_pick);
        pay_out_r <= PAYLOAD_W'(pay_pick);
      end else begin
        key_out_r <= '0;
        pay_out_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.execute) begin
      count_r <= count_nxt;
    end
  end

  assign out_status  = status_r;
  assign out_key     = key_out_r;
  assign out_payload = pay_out_r;
  assign out_count   = count_out_r;

endmodule

@@ hdl/sorted_key_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Bounded table of key/payload entries kept in ascending key order.
// ----------------------------------------------------------------------------
// Each transaction is accepted and then executed: in the accept cycle every
// stored entry is compared against the key and the rank in parallel, and in the
// execute state the entry chain shifts by one place for an insert or delete
// while the result is loaded into the output register. That update waits
// while a previous result is still held on the output, so a stalled consumer
// delays it. Commands on in_tuser: insert, search, delete, read at rank.
// Results carry a status on out_tuser and the entry count after the
// operation. The table starts empty after reset; no clearing pass is needed.
module sorted_key_table_core #(
  parameter int unsigned CAPACITY     = skt_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS     = skt_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // key_in[15:0], payload_in[31:16], rank_in[37:32], zero[39:38]
  input  logic [skt_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  logic [skt_pkg::CMD_W-1:0]        in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // key_out[15:0], payload_out[31:16], entry_count[38:32], zero[39]
  output logic [skt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status[2:0]
  output logic [skt_pkg::STATUS_W-1:0]     out_tuser
);
  import skt_pkg::*;

  skt_ctrl_t            ctrl;
  logic [KEY_W-1:0]     key_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [COUNT_W-1:0]   entry_count;

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctrl       (ctrl)
  );

  skt_datapath #(
    .CAPACITY     (CAPACITY),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_cmd      (in_tuser),
    .in_key      (in_tdata[15:0]),
    .in_payload  (in_tdata[31:16]),
    .in_rank     (in_tdata[37:32]),
    .out_status  (out_tuser),
    .out_key     (key_out),
    .out_payload (payload_out),
    .out_count   (entry_count)
  );

  assign out_tdata = {1'b0, entry_count, payload_out, key_out};

endmodule
